/* sv/lsfr_pkg.sv */
// Shared constants and types for the line sensor frame receiver.
`timescale 1ns / 1ps

package lsfr_pkg;

	// Longest frame held before it is dropped as overlong.
	localparam int MAX_FRAME_BYTES = 9;
	// Number of kept transition locations.
	localparam int LOC_SLOTS       = 6;

	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 3;
	localparam int POS_W   = $clog2(MAX_FRAME_BYTES + 1);
	localparam int HDR_N_W = 4;
	localparam int CMP_W   = ((POS_W > HDR_N_W) ? POS_W : HDR_N_W) + 1;

	// Header byte layout.
	localparam int HDR_COLOR_BIT = 7;

	// Byte positions inside a frame.
	localparam logic [POS_W-1:0] POS_IDLE   = POS_W'(0);
	localparam logic [POS_W-1:0] POS_HEADER = POS_W'(1);
	localparam logic [POS_W-1:0] POS_BODY   = POS_W'(2);
	localparam logic [POS_W-1:0] POS_FULL   = POS_W'(MAX_FRAME_BYTES);

	// Configuration port.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-3:0] REG_START_BYTE = '0;

	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [POS_W-1:0]   pos_t;

	// Saturate a header count to the number of kept slots.
	function automatic count_t sat_count(input logic [HDR_N_W-1:0] n);
		if (32'(n) > LOC_SLOTS) begin
			return COUNT_W'(LOC_SLOTS);
		end
		return COUNT_W'(n);
	endfunction

endpackage

/* sv/lsfr_in_if.sv */
// Byte stream channel into the frame receiver.
`timescale 1ns / 1ps

interface lsfr_in_if;
	import lsfr_pkg::*;

	logic  valid;
	logic  ready;
	byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

/* sv/lsfr_out_if.sv */
// Frame result channel out of the frame receiver.
`timescale 1ns / 1ps

interface lsfr_out_if;
	import lsfr_pkg::*;

	logic   valid;
	logic   ready;
	logic   frame_good;
	logic   start_color;
	count_t transition_count;
	byte_t  location_0;
	byte_t  location_1;
	byte_t  location_2;
	byte_t  location_3;
	byte_t  location_4;
	byte_t  location_5;

	modport source (
		output valid, output frame_good, output start_color, output transition_count,
		output location_0, output location_1, output location_2,
		output location_3, output location_4, output location_5,
		input ready
	);
	modport sink (
		input valid, input frame_good, input start_color, input transition_count,
		input location_0, input location_1, input location_2,
		input location_3, input location_4, input location_5,
		output ready
	);
endinterface

/* sv/line_sensor_frame_receiver.sv */
// Top level of the line sensor frame receiver: byte parser, checksum and kept frame.
`timescale 1ns / 1ps

// Line sensor frame receiver. Takes one received byte per transaction on rx and
// parses frames of the form: start byte, header byte (bit 7 starting color, low
// nibble transition count n), n location bytes, checksum byte (low 8 bits of the
// sum of all earlier frame bytes). Every completed frame yields one transaction
// on res carrying frame_good and the color, count and locations of the last good
// frame; a bad checksum leaves the kept values alone. Bytes that arrive while
// idle and do not match the start_byte register are discarded. A frame that
// holds MAX_FRAME_BYTES bytes without completing is dropped with no result, and
// the byte after it is discarded too. Rate: one byte per clock cycle, sustained
// while the input side does not stall. A byte is held in the input register,
// where the parser and checksum logic act on it, and the result of a checksum
// byte enters the output register as that byte leaves the input register.
// The input side stalls only when a finished frame meets a full result register
// that is not being drained. The start_byte register sits at byte address 0 of
// the APB port; write it only while no frame is in flight.
module line_sensor_frame_receiver (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lsfr_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [lsfr_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [lsfr_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	lsfr_in_if.sink                          rx,
	lsfr_out_if.source                       res
);
	import lsfr_pkg::*;

	// Configuration
	byte_t start_q;
	logic  reg_hit;

	// Input register
	logic  valid_s1;
	byte_t byte_s1;

	// Parser state
	pos_t  pos_q;
	byte_t sum_q;
	byte_t hdr_q;
	byte_t loc_buf_q [LOC_SLOTS];

	// Kept frame
	logic   kept_color_q;
	count_t kept_count_q;
	byte_t  kept_loc_q [LOC_SLOTS];

	// Result register
	logic   res_valid_q;
	logic   res_good_q;
	logic   res_color_q;
	count_t res_count_q;
	byte_t  res_loc_q [LOC_SLOTS];

	// Decode
	logic   ph_overlong;
	logic   ph_idle;
	logic   ph_header;
	logic   ph_body;
	logic   ph_check;
	logic   has_result;
	logic   out_free;
	logic   fire_s1;
	logic   good;
	logic   color_nx;
	count_t count_nx;
	byte_t  loc_nx [LOC_SLOTS];

	// ---------------------------------------------------------------
	// APB register: one write per access phase, no wait states.
	// ---------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_START_BYTE);
	assign prdata  = reg_hit ? APB_DATA_W'(start_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			start_q <= pwdata[BYTE_W-1:0];
		end
	end

	// ---------------------------------------------------------------
	// Frame phase of the byte in the input register.
	// ---------------------------------------------------------------
	always_comb begin
		ph_overlong = (pos_q >= POS_FULL);
		ph_idle     = (pos_q == POS_IDLE);
		ph_header   = (pos_q == POS_HEADER);
		// A byte is a location byte while pos + 1 < n + 3.
		ph_body     = !ph_overlong && (pos_q >= POS_BODY) &&
			(CMP_W'(pos_q) < CMP_W'(hdr_q[HDR_N_W-1:0]) + CMP_W'(2));
		ph_check    = !ph_overlong && (pos_q >= POS_BODY) && !ph_body;
	end

	assign has_result = valid_s1 && ph_check;
	assign out_free   = !res_valid_q || res.ready;
	// Hold the byte only when its result cannot enter the result register.
	assign fire_s1    = valid_s1 && (!has_result || out_free);
	assign rx.ready   = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// ---------------------------------------------------------------
	// Checksum compare and next kept values.
	// ---------------------------------------------------------------
	always_comb begin
		good     = (byte_s1 == sum_q);
		color_nx = kept_color_q;
		count_nx = kept_count_q;
		for (int i = 0; i < LOC_SLOTS; i++) begin
			loc_nx[i] = kept_loc_q[i];
		end
		if (good) begin
			color_nx = hdr_q[HDR_COLOR_BIT];
			count_nx = sat_count(hdr_q[HDR_N_W-1:0]);
			// Clear slots beyond the new count.
			for (int i = 0; i < LOC_SLOTS; i++) begin
				if ((COUNT_W'(i) < count_nx) && (i + 2 < MAX_FRAME_BYTES)) begin
					loc_nx[i] = loc_buf_q[i];
				end else begin
					loc_nx[i] = '0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Parser state: position and running sum.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_IDLE;
			sum_q <= '0;
		end else if (fire_s1) begin
			priority if (ph_overlong) begin
				// Drop the overlong frame together with this byte.
				pos_q <= POS_IDLE;
				sum_q <= '0;
			end else if (ph_idle) begin
				if (byte_s1 == start_q) begin
					pos_q <= POS_HEADER;
					sum_q <= byte_s1;
				end
			end else if (ph_check) begin
				pos_q <= POS_IDLE;
				sum_q <= '0;
			end else begin
				// Header or location byte: advance and accumulate.
				pos_q <= pos_q + POS_W'(1);
				sum_q <= sum_q + byte_s1;
			end
		end
	end

	// Frame buffer: only the header and the location bytes are ever read back.
	always_ff @(posedge clk) begin
		if (fire_s1 && ph_header) begin
			hdr_q <= byte_s1;
		end
		for (int i = 0; i < LOC_SLOTS; i++) begin
			if (fire_s1 && ph_body && (pos_q == POS_W'(i + 2))) begin
				loc_buf_q[i] <= byte_s1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Kept frame: updated only by a good checksum.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_color_q <= 1'b0;
			kept_count_q <= '0;
			for (int i = 0; i < LOC_SLOTS; i++) begin
				kept_loc_q[i] <= '0;
			end
		end else if (fire_s1 && ph_check) begin
			kept_color_q <= color_nx;
			kept_count_q <= count_nx;
			for (int i = 0; i < LOC_SLOTS; i++) begin
				kept_loc_q[i] <= loc_nx[i];
			end
		end
	end

	// ---------------------------------------------------------------
	// Result register.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire_s1 && has_result) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && has_result) begin
			res_good_q  <= good;
			res_color_q <= color_nx;
			res_count_q <= count_nx;
			for (int i = 0; i < LOC_SLOTS; i++) begin
				res_loc_q[i] <= loc_nx[i];
			end
		end
	end

	assign res.valid            = res_valid_q;
	assign res.frame_good       = res_good_q;
	assign res.start_color      = res_color_q;
	assign res.transition_count = res_count_q;
	assign res.location_0       = res_loc_q[0];
	assign res.location_1       = res_loc_q[1];
	assign res.location_2       = res_loc_q[2];
	assign res.location_3       = res_loc_q[3];
	assign res.location_4       = res_loc_q[4];
	assign res.location_5       = res_loc_q[5];

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_pos_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_FULL)
		else $error("frame position beyond the frame limit");

	a_idle_discard: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && ph_idle && (byte_s1 != start_q)) |=> (pos_q == POS_IDLE))
		else $error("non-start byte left the parser idle state");

	a_res_matches_kept: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> ((res_color_q == kept_color_q) && (res_count_q == kept_count_q)))
		else $error("pending result disagrees with the kept frame");

	a_kept_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(kept_count_q) <= LOC_SLOTS)
		else $error("kept count above the slot count");

	a_kept_tail_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(kept_count_q) < LOC_SLOTS) |-> (kept_loc_q[LOC_SLOTS-1] == '0))
		else $error("kept location beyond the count is not cleared");

endmodule

/* verif/line_sensor_frame_receiver_test.sv */
// Testbench for the line sensor frame receiver: byte frames checked against a frame predictor.
`timescale 1ns / 1ps

module line_sensor_frame_receiver_test;
	import lsfr_pkg::*;

	// Start, header and checksum bytes around the location bytes.
	localparam int FRAME_OVERHEAD   = 3;
	// Location bytes held before an overlong frame runs into the buffer limit.
	localparam int BODY_LIMIT       = MAX_FRAME_BYTES - 2;
	// Input register plus output register, with margin.
	localparam int SETTLE_CYCLES    = 6;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int PHASE_BYTES      = 250;
	localparam int PHASE_COUNT      = 6;
	localparam int CYCLE_LIMIT      = 400000;

	typedef struct packed {
		logic                     good;
		logic                     color;
		count_t                   count;
		byte_t [LOC_SLOTS-1:0]    loc;
	} frame_result_t;

	// Tracks the parser state and the kept frame, queues the result each completed
	// frame should produce, and checks results against that queue in order.
	class frame_checker;
		byte_t         start_value;
		int unsigned   held;
		byte_t         held_bytes[MAX_FRAME_BYTES];
		byte_t         sum;
		logic          kept_color;
		count_t        kept_count;
		byte_t         kept_loc[LOC_SLOTS];
		frame_result_t expected_frames[$];
		int unsigned   errors;

		function new();
			start_value = '0;
			held        = 0;
			sum         = '0;
			kept_color  = 1'b0;
			kept_count  = '0;
			errors      = 0;
			foreach (held_bytes[i]) held_bytes[i] = '0;
			foreach (kept_loc[i]) kept_loc[i] = '0;
		endfunction

		function void take(byte_t b);
			if (held < MAX_FRAME_BYTES) begin
				held_bytes[held] = b;
			end
			held++;
			sum += b;
		endfunction

		// Advance the parser by one accepted byte; return 0 if the byte was ignored.
		function bit note_rx_byte(byte_t b);
			int unsigned   n;
			bit            good;
			frame_result_t want;
			if (held >= MAX_FRAME_BYTES) begin
				// Overlong frame: drop this byte, whatever it is, and go idle.
				held = 0;
				sum  = '0;
				return 1'b1;
			end
			if (held == 0) begin
				if (b != start_value) begin
					return 1'b0;
				end
				sum = '0;
				take(b);
				return 1'b1;
			end
			if (held == 1) begin
				take(b);
				return 1'b1;
			end
			n = 32'(held_bytes[1][HDR_N_W-1:0]);
			if (held + 1 < n + FRAME_OVERHEAD) begin
				take(b);
				return 1'b1;
			end
			// This byte is the checksum.
			good = (b == sum);
			if (good) begin
				kept_color = held_bytes[1][HDR_COLOR_BIT];
				kept_count = (n > LOC_SLOTS) ? count_t'(LOC_SLOTS) : count_t'(n);
				for (int i = 0; i < LOC_SLOTS; i++) begin
					kept_loc[i] = (i < kept_count && 2 + i < MAX_FRAME_BYTES) ?
						held_bytes[2 + i] : '0;
				end
			end
			held = 0;
			sum  = '0;
			want.good  = good;
			want.color = kept_color;
			want.count = kept_count;
			for (int i = 0; i < LOC_SLOTS; i++) begin
				want.loc[i] = kept_loc[i];
			end
			expected_frames.push_back(want);
			return 1'b1;
		endfunction

		function void check_result(frame_result_t got);
			frame_result_t want;
			if (expected_frames.size() == 0) begin
				$error("frame result arrived with none expected");
				errors++;
				return;
			end
			want = expected_frames.pop_front();
			if (got.good !== want.good) begin
				$error("frame_good: expected %0d, got %0d", want.good, got.good);
				errors++;
			end
			if (got.color !== want.color) begin
				$error("start_color: expected %0d, got %0d", want.color, got.color);
				errors++;
			end
			if (got.count !== want.count) begin
				$error("transition_count: expected %0d, got %0d", want.count, got.count);
				errors++;
			end
			for (int i = 0; i < LOC_SLOTS; i++) begin
				if (got.loc[i] !== want.loc[i]) begin
					$error("location_%0d: expected %0d, got %0d", i, want.loc[i], got.loc[i]);
					errors++;
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	lsfr_in_if  rx_ch ();
	lsfr_out_if res_ch ();

	frame_checker frames = new();

	// Drop all idling on both sides in the last part of the run.
	bit          no_idle       = 1'b0;
	// Ask the result side for one long hold-off.
	bit          long_hold_req = 1'b0;
	int unsigned bytes_used    = 0;
	int unsigned cycle_count   = 0;

	line_sensor_frame_receiver u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rx      (rx_ch),
		.res     (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side: check every result transaction and stall ready in random bursts,
	// plus one long hold-off on request so that the block backs up into its input.
	initial begin : result_side
		int unsigned   stall_left;
		frame_result_t got;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				got.good  = res_ch.frame_good;
				got.color = res_ch.start_color;
				got.count = res_ch.transition_count;
				got.loc   = {res_ch.location_5, res_ch.location_4, res_ch.location_3,
					res_ch.location_2, res_ch.location_1, res_ch.location_0};
				frames.check_result(got);
			end
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left    = LONG_HOLD_CYCLES;
			end else if (stall_left == 0 && !no_idle && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 7);
			end
			if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Offer one byte, with an occasional gap ahead of it, and hold it until accepted.
	task automatic send_byte(input byte_t b);
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			rx_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		bytes_used += frames.note_rx_byte(b);
	endtask

	// Send one frame with n location bytes. fixed_loc below zero means random
	// locations. For a frame that fits, odd corrupts the checksum; for an overlong
	// one, odd offers the start byte as the byte that the parser drops.
	task automatic send_frame(input bit color, input int unsigned n, input int fixed_loc,
			input bit odd);
		byte_t       hdr;
		byte_t       b;
		byte_t       sum;
		int unsigned body;
		hdr  = {color, 3'($urandom), 4'(n)};
		sum  = frames.start_value + hdr;
		body = (n + FRAME_OVERHEAD > MAX_FRAME_BYTES) ? BODY_LIMIT : n;
		send_byte(frames.start_value);
		send_byte(hdr);
		for (int unsigned i = 0; i < body; i++) begin
			b = (fixed_loc < 0) ? byte_t'($urandom) : byte_t'(fixed_loc);
			sum += b;
			send_byte(b);
		end
		if (n + FRAME_OVERHEAD > MAX_FRAME_BYTES) begin
			send_byte(odd ? frames.start_value : byte_t'($urandom));
		end else begin
			send_byte(odd ? byte_t'(sum + $urandom_range(1, 255)) : sum);
		end
	endtask

	// Mostly well-formed frames; the rest bad checksums, overlong frames and loose
	// bytes that often carry the start value and so break into frames.
	task automatic run_random(input int unsigned target);
		int unsigned goal;
		int unsigned pick;
		goal = bytes_used + target;
		while (bytes_used < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				send_frame(1'($urandom_range(0, 1)), $urandom_range(0, LOC_SLOTS), -1, 1'b0);
			end else if (pick < 80) begin
				send_frame(1'($urandom_range(0, 1)), $urandom_range(0, LOC_SLOTS), -1, 1'b1);
			end else if (pick < 87) begin
				send_frame(1'($urandom_range(0, 1)), $urandom_range(LOC_SLOTS + 1, 15), -1,
					1'($urandom_range(0, 1)));
			end else begin
				repeat ($urandom_range(1, 5)) begin
					send_byte(($urandom_range(0, 3) == 0) ? frames.start_value :
						byte_t'($urandom));
				end
			end
		end
	endtask

	// Bring the parser back to idle, hold the input until every result is in,
	// then let the pipeline empty.
	task automatic drain_to_idle();
		// Filler bytes finish or overrun any frame in flight.
		while (frames.held != 0) begin
			send_byte(8'h00);
		end
		rx_ch.valid <= 1'b0;
		while (frames.expected_frames.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_start_byte(input byte_t value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_START_BYTE, 2'b00};
		pwdata  <= {24'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		frames.start_value = value;
	endtask

	initial begin : stimulus
		byte_t start_value;
		arst_n        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		rx_ch.valid   <= 1'b0;
		rx_ch.rx_byte <= '0;
		res_ch.ready  <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, start byte still at its reset value of zero.
		// A non-start byte while idle is thrown away.
		send_byte(8'h5A);
		// Full frame with every location at the top of its range.
		send_frame(1'b1, LOC_SLOTS, 255, 1'b0);
		// Empty good frame clears every kept location.
		send_frame(1'b0, 0, 0, 1'b0);
		// Bad checksum leaves the kept frame alone.
		send_frame(1'b1, 2, -1, 1'b1);
		// Largest count overruns the buffer; the start byte after it is dropped.
		send_frame(1'b0, 15, 0, 1'b1);

		// Random phases, each under its own start byte.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: start_value = 8'hFF;
				1: start_value = 8'h00;
				default: start_value = byte_t'($urandom);
			endcase
			if (p == PHASE_COUNT - 1) begin
				no_idle = 1'b1;
			end
			drain_to_idle();
			write_start_byte(start_value);
			if (p == 2) begin
				long_hold_req = 1'b1;
			end
			if (p == 3) begin
				run_random(PHASE_BYTES / 2);
				drain_to_idle();
				run_random(PHASE_BYTES / 2);
			end else begin
				run_random(PHASE_BYTES);
			end
		end

		drain_to_idle();
		if (frames.errors == 0 && frames.expected_frames.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* files.f */
sv/lsfr_pkg.sv
sv/lsfr_in_if.sv
sv/lsfr_out_if.sv
sv/line_sensor_frame_receiver.sv
verif/line_sensor_frame_receiver_test.sv
